// ===== hdl/g2e_pkg.sv =====
// Shared types, constants and widths for the geodetic to earth-centred converter.
// Depends on nothing; every other file but g2e_dly and g2e_mul imports it.
`timescale 1ns / 1ps
package g2e_pkg;

  localparam int ANG_W    = 32;
  localparam int H_W      = 36;
  localparam int CRD_W    = 38;
  localparam int RAD_W    = 33;
  localparam int ECC_W    = 48;
  localparam int CFG_W    = 48;
  localparam int TURN_W   = 48;
  localparam int CW       = 44;
  localparam int SC_W     = 42;
  localparam int K_W      = 5;

  localparam int CORDIC_STAGES_DEF = 32;
  localparam int MUL_LAT  = 2;
  localparam int TURN_LAT = 4;
  localparam int NU_LAT   = 54;
  localparam int SMUL_LAT = 5;
  localparam int NEWTON_ITERS = 6;

  localparam logic [RAD_W-1:0] RADIUS_RST = 33'd6531212288;
  localparam logic [ECC_W-1:0] ECC_RST    = 48'd1884300451818;

  localparam logic [63:0] PI60      = 64'h3243F6A8885A308D;
  localparam logic [63:0] PI61      = 64'h6487ED5110B4611A;
  localparam logic [32:0] RAD2TURN  = 33'h145F306DD;
  localparam logic [32:0] DEG_RECIP = 33'h16C16C16D;
  localparam logic signed [CW-1:0] KGAIN40 = 44'sd667681663043;
  localparam logic [48:0] ONE48     = 49'h1_0000_0000_0000;
  localparam logic [63:0] THREE61   = 64'h6000_0000_0000_0000;
  localparam logic [63:0] Y0_BASE   = 64'h4800_0000_0000_0000;
  localparam logic [127:0] ROUND40  = 128'h80_0000_0000;
  localparam logic signed [CW-1:0] ONE40 = 44'sd1099511627776;

  typedef enum logic [1:0] {
    CFG_RADIUS = 2'd0,
    CFG_ECC    = 2'd1,
    CFG_DEG    = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    QUAD_I   = 2'd0,
    QUAD_II  = 2'd1,
    QUAD_III = 2'd2,
    QUAD_IV  = 2'd3
  } quad_t;

  // Arctangent of 2^-idx in Q.40 radians, built from the arctangent series.
  function automatic logic [40:0] atan_q40(input int idx);
    longint unsigned acc;
    longint unsigned term;
    int e;
    acc = 64'd0;
    if (idx == 0) begin
      acc = (PI60 + 64'd2097152) >> 22;
    end else begin
      for (int k = 0; k < 61; k++) begin
        e = 60 - idx * (2 * k + 1);
        if (e >= 0) begin
          term = (64'd1 << e) / 64'(2 * k + 1);
          if (k % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
      end
      acc = (acc + 64'd524288) >> 20;
    end
    return 41'(acc);
  endfunction

endpackage

// ===== hdl/g2e_dly.sv =====
// Fixed-length delay line with a shared advance enable.
// Depends on nothing.
`timescale 1ns / 1ps
module g2e_dly #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe_r [D];

  always_ff @(posedge clk) begin
    if (en) begin
      pipe_r[0] <= d;
      for (int i = 1; i < D; i++) begin
        pipe_r[i] <= pipe_r[i-1];
      end
    end
  end

  assign q = pipe_r[D-1];

endmodule

// ===== hdl/g2e_mul.sv =====
// Two-stage unsigned 64 by 64 multiplier built from four 32 by 32 partial products.
// Depends on nothing.
`timescale 1ns / 1ps
module g2e_mul (
  input  logic          clk,
  input  logic          en,
  input  logic [63:0]   a,
  input  logic [63:0]   b,
  output logic [127:0]  p
);

  logic [63:0]  ll_r, lh_r, hl_r, hh_r;
  logic [127:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ll_r <= 64'(a[31:0]) * 64'(b[31:0]);
      lh_r <= 64'(a[31:0]) * 64'(b[63:32]);
      hl_r <= 64'(a[63:32]) * 64'(b[31:0]);
      hh_r <= 64'(a[63:32]) * 64'(b[63:32]);
      p_r  <= 128'(ll_r) + (128'(lh_r) << 32) + (128'(hl_r) << 32) + (128'(hh_r) << 64);
    end
  end

  assign p = p_r;

endmodule

// ===== hdl/g2e_smul.sv =====
// Signed product scaled by 2^-40 with rounding half away from zero, five stages.
// Depends on g2e_pkg, g2e_mul and g2e_dly.
`timescale 1ns / 1ps
module g2e_smul (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  output logic signed [63:0] p
);
  import g2e_pkg::*;

  logic         neg_r, neg_d, neg4_r;
  logic [63:0]  am_r, bm_r, rnd_r;
  logic [127:0] pm;
  logic [127:0] psum;
  logic signed [63:0] p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r <= a[63] ^ b[63];
      am_r  <= a[63] ? (~a + 64'd1) : a;
      bm_r  <= b[63] ? (~b + 64'd1) : b;
    end
  end

  g2e_mul u_mul (.clk(clk), .en(en), .a(am_r), .b(bm_r), .p(pm));
  g2e_dly #(.W(1), .D(MUL_LAT)) u_negd (.clk(clk), .en(en), .d(neg_r), .q(neg_d));

  assign psum = pm + ROUND40;

  always_ff @(posedge clk) begin
    if (en) begin
      rnd_r  <= psum[103:40];
      neg4_r <= neg_d;
      p_r    <= neg4_r ? -signed'(rnd_r) : signed'(rnd_r);
    end
  end

  assign p = p_r;

endmodule

// ===== hdl/g2e_turns.sv =====
// Converts a radian or degree angle into a 48-bit fraction of a full turn, four stages.
// Depends on g2e_pkg.
`timescale 1ns / 1ps
module g2e_turns (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         deg_mode,
  input  logic signed [g2e_pkg::ANG_W-1:0] angle,
  output logic [g2e_pkg::TURN_W-1:0]   turns
);
  import g2e_pkg::*;

  logic        neg_r, neg2_r, neg3_r;
  logic [31:0] mag_r, mag2_r;
  logic [64:0] prad_r, pdeg_r;
  logic [64:0] rsum;
  logic [26:0] qm_r;
  logic [5:0]  rm_r;
  logic [32:0] rem;
  logic [TURN_W-1:0] trad_r;
  logic [10:0] sm;
  logic [21:0] fr;
  logic [TURN_W-1:0] tdeg, tsel, turns_nxt, turns_r;

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r  <= angle[ANG_W-1];
      mag_r  <= angle[ANG_W-1] ? (~angle + 32'd1) : angle;
      neg2_r <= neg_r;
      mag2_r <= mag_r;
      prad_r <= 65'(mag_r) * 65'(RAD2TURN);
      pdeg_r <= 65'(mag_r) * 65'(DEG_RECIP);
    end
  end

  assign rsum = prad_r + 65'd32768;
  assign rem  = 33'(mag2_r) - 33'(pdeg_r[64:38]) * 33'd45;

  always_ff @(posedge clk) begin
    if (en) begin
      neg3_r <= neg2_r;
      trad_r <= rsum[63:16];
      qm_r   <= pdeg_r[64:38];
      rm_r   <= rem[5:0];
    end
  end

  always_comb begin
    sm        = 11'(rm_r) * 11'd34 + 11'd22;
    fr        = 22'(sm) * 22'd1457;
    tdeg      = (48'(qm_r) << 22) + 48'(rm_r) * 48'd93206 + 48'(fr[21:16]);
    tsel      = deg_mode ? tdeg : trad_r;
    turns_nxt = neg3_r ? (~tsel + 48'd1) : tsel;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      turns_r <= turns_nxt;
    end
  end

  assign turns = turns_r;

endmodule

// ===== hdl/g2e_cordic.sv =====
// Pipelined rotation CORDIC giving the clamped cosine and sine of a turn fraction.
// Depends on g2e_pkg, g2e_mul and g2e_dly.
`timescale 1ns / 1ps
module g2e_cordic #(
  parameter int STAGES = g2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic [g2e_pkg::TURN_W-1:0]       turns,
  output logic signed [g2e_pkg::SC_W-1:0]  cos_o,
  output logic signed [g2e_pkg::SC_W-1:0]  sin_o
);
  import g2e_pkg::*;

  logic [127:0] pz;
  logic signed [CW-1:0] z0;
  logic signed [CW-1:0] x_r [STAGES];
  logic signed [CW-1:0] y_r [STAGES];
  logic signed [CW-1:0] z_r [STAGES];
  logic [1:0] quad_d;
  logic signed [CW-1:0] xc, yc;
  logic signed [SC_W-1:0] cos_nxt, sin_nxt, cos_r, sin_r;

  g2e_mul u_mul (.clk(clk), .en(en), .a(64'(turns[TURN_W-3:0])), .b(PI61), .p(pz));
  g2e_dly #(.W(2), .D(MUL_LAT + STAGES)) u_quad (
    .clk(clk), .en(en), .d(turns[TURN_W-1:TURN_W-2]), .q(quad_d)
  );

  assign z0 = signed'(CW'(pz[108:68]));

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [CW-1:0] ATAN_I = signed'(CW'(atan_q40(i)));
    logic signed [CW-1:0] xi, yi, zi;
    if (i == 0) begin : g_first
      assign xi = KGAIN40;
      assign yi = '0;
      assign zi = z0;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (!zi[CW-1]) begin
          x_r[i] <= xi - (yi >>> i);
          y_r[i] <= yi + (xi >>> i);
          z_r[i] <= zi - ATAN_I;
        end else begin
          x_r[i] <= xi + (yi >>> i);
          y_r[i] <= yi - (xi >>> i);
          z_r[i] <= zi + ATAN_I;
        end
      end
    end
  end

  always_comb begin
    xc = x_r[STAGES-1];
    yc = y_r[STAGES-1];
    if (xc > ONE40) xc = ONE40;
    if (xc < -ONE40) xc = -ONE40;
    if (yc > ONE40) yc = ONE40;
    if (yc < -ONE40) yc = -ONE40;
    case (quad_t'(quad_d))
      QUAD_I: begin
        cos_nxt = SC_W'(xc);
        sin_nxt = SC_W'(yc);
      end
      QUAD_II: begin
        cos_nxt = SC_W'(-yc);
        sin_nxt = SC_W'(xc);
      end
      QUAD_III: begin
        cos_nxt = SC_W'(-xc);
        sin_nxt = SC_W'(-yc);
      end
      default: begin
        cos_nxt = SC_W'(yc);
        sin_nxt = SC_W'(-xc);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule

// ===== hdl/g2e_nu.sv =====
// Prime vertical radius of curvature a/sqrt(1 - e2 sin^2 lat) with Newton iterations.
// Depends on g2e_pkg, g2e_mul and g2e_dly.
`timescale 1ns / 1ps
module g2e_nu (
  input  logic                            clk,
  input  logic                            en,
  input  logic [g2e_pkg::RAD_W-1:0]       radius,
  input  logic [g2e_pkg::ECC_W-1:0]       ecc,
  input  logic signed [g2e_pkg::SC_W-1:0] slat,
  output logic [63:0]                     nu
);
  import g2e_pkg::*;

  logic [40:0]  sm_r;
  logic [127:0] pa, pb, pn;
  logic [48:0]  t_r, t2_r;
  logic [5:0]   msb;
  logic [K_W-1:0] k_nxt, k_r, k2_r, k3_r, k_d;
  logic [63:0]  m_r, m0_r, y0_r;
  logic [63:0]  y_s [NEWTON_ITERS+1];
  logic [63:0]  m_s [NEWTON_ITERS];
  logic [6:0]   shamt;
  logic [63:0]  nu_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sm_r <= slat[SC_W-1] ? 41'(-slat) : 41'(slat);
    end
  end

  g2e_mul u_sq  (.clk(clk), .en(en), .a(64'(sm_r)), .b(64'(sm_r)), .p(pa));
  g2e_mul u_ecc (.clk(clk), .en(en), .a(64'(ecc)), .b(64'(pa[80:40])), .p(pb));

  always_comb begin
    msb = '0;
    for (int b = 0; b < 49; b++) begin
      if (t_r[b]) msb = 6'(b);
    end
    k_nxt = K_W'((7'd61 - 7'(msb)) >> 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r  <= ONE48 - pb[88:40];
      t2_r <= t_r;
      k_r  <= k_nxt;
      m_r  <= 64'(t2_r) << {k_r, 1'b0};
      k2_r <= k_r;
      m0_r <= m_r;
      y0_r <= Y0_BASE - ((m_r >> 1) + (m_r >> 3));
      k3_r <= k2_r;
    end
  end

  assign y_s[0] = y0_r;
  assign m_s[0] = m0_r;

  for (genvar j = 0; j < NEWTON_ITERS; j++) begin : g_iter
    logic [127:0] p_sq, p_my, p_yf;
    logic [63:0]  m_d2, y_d5, pv, f_r;

    g2e_mul u_yy (.clk(clk), .en(en), .a(y_s[j]), .b(y_s[j]), .p(p_sq));
    g2e_dly #(.W(64), .D(MUL_LAT)) u_md (.clk(clk), .en(en), .d(m_s[j]), .q(m_d2));
    g2e_mul u_my (.clk(clk), .en(en), .a(m_d2), .b(p_sq[124:61]), .p(p_my));

    assign pv = p_my[125:62];
    always_ff @(posedge clk) begin
      if (en) begin
        f_r <= (pv >= THREE61) ? 64'd0 : (THREE61 - pv);
      end
    end

    g2e_dly #(.W(64), .D(2 * MUL_LAT + 1)) u_yd (.clk(clk), .en(en), .d(y_s[j]), .q(y_d5));
    g2e_mul u_yf (.clk(clk), .en(en), .a(y_d5), .b(f_r), .p(p_yf));
    assign y_s[j+1] = p_yf[125:62];

    if (j < NEWTON_ITERS - 1) begin : g_mnext
      g2e_dly #(.W(64), .D(MUL_LAT + 1 + MUL_LAT)) u_mn (
        .clk(clk), .en(en), .d(m_d2), .q(m_s[j+1])
      );
    end
  end

  g2e_dly #(.W(K_W), .D(NEWTON_ITERS * (3 * MUL_LAT + 1) + MUL_LAT)) u_kd (
    .clk(clk), .en(en), .d(k3_r), .q(k_d)
  );
  g2e_mul u_nu (.clk(clk), .en(en), .a(64'(radius)), .b(y_s[NEWTON_ITERS]), .p(pn));

  assign shamt = 7'd68 - 7'(k_d);

  always_ff @(posedge clk) begin
    if (en) begin
      nu_r <= 64'(pn >> shamt);
    end
  end

  assign nu = nu_r;

endmodule

// ===== hdl/geodetic_to_ecef.sv =====
// Geodetic longitude, latitude and height to earth-centred X, Y, Z: top level.
// Depends on g2e_pkg, g2e_turns, g2e_cordic, g2e_nu, g2e_mul, g2e_smul and g2e_dly.
// The block takes one beat per clock while the output is not stalled; most of the pipeline
// depth comes from the CORDIC rotations and from the six Newton steps of the inverse
// square root, each three multiplies deep.
// A stalled output freezes the whole pipeline, so input is refused only while a finished
// beat waits on the output. Configuration writes are always taken and act at once, so
// they belong to moments when no beat is in flight.
`timescale 1ns / 1ps
module geodetic_to_ecef #(
  parameter int CORDIC_STAGES = g2e_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [g2e_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [g2e_pkg::ANG_W-1:0]     in_longitude,
  input  logic signed [g2e_pkg::ANG_W-1:0]     in_latitude,
  input  logic signed [g2e_pkg::H_W-1:0]       in_height,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [g2e_pkg::CRD_W-1:0]     out_coord_x,
  output logic signed [g2e_pkg::CRD_W-1:0]     out_coord_y,
  output logic signed [g2e_pkg::CRD_W-1:0]     out_coord_z
);
  import g2e_pkg::*;

  localparam int TC    = TURN_LAT + MUL_LAT + CORDIC_STAGES + 1;
  localparam int LAT   = TC + NU_LAT + MUL_LAT + 1 + 2 * SMUL_LAT + 1;
  localparam int HDLY  = TC + NU_LAT + MUL_LAT;
  localparam int TDLY  = NU_LAT + MUL_LAT + 1;
  localparam logic signed [63:0] SAT_HI = 64'sd137438953471;
  localparam logic signed [63:0] SAT_LO = -64'sd137438953472;

  logic [RAD_W-1:0] radius_r;
  logic [ECC_W-1:0] ecc_r;
  logic             deg_r;
  logic [LAT-1:0]   vld_r;
  logic             en;

  logic [TURN_W-1:0] tlon, tlat;
  logic signed [SC_W-1:0] clon, slon, clat, slat;
  logic signed [SC_W-1:0] clat_d, slat_d, clon_d, slon_d;
  logic [63:0] nu, nu_d;
  logic signed [H_W-1:0] h_d;
  logic [127:0] pz;
  logic signed [63:0] nh_r, nz_r, pc, xs, ys, zs, zs_d;
  logic signed [CRD_W-1:0] x_r, y_r, z_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RST;
      ecc_r    <= ECC_RST;
      deg_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_RADIUS: radius_r <= cfg_data[RAD_W-1:0];
        CFG_ECC:    ecc_r    <= cfg_data[ECC_W-1:0];
        CFG_DEG:    deg_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign en        = !vld_r[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  g2e_turns u_tlon (.clk(clk), .en(en), .deg_mode(deg_r), .angle(in_longitude), .turns(tlon));
  g2e_turns u_tlat (.clk(clk), .en(en), .deg_mode(deg_r), .angle(in_latitude), .turns(tlat));

  g2e_cordic #(.STAGES(CORDIC_STAGES)) u_clon (
    .clk(clk), .en(en), .turns(tlon), .cos_o(clon), .sin_o(slon)
  );
  g2e_cordic #(.STAGES(CORDIC_STAGES)) u_clat (
    .clk(clk), .en(en), .turns(tlat), .cos_o(clat), .sin_o(slat)
  );

  g2e_nu u_nu (.clk(clk), .en(en), .radius(radius_r), .ecc(ecc_r), .slat(slat), .nu(nu));

  g2e_dly #(.W(H_W), .D(HDLY)) u_hd (.clk(clk), .en(en), .d(in_height), .q(h_d));
  g2e_dly #(.W(64), .D(MUL_LAT)) u_nud (.clk(clk), .en(en), .d(nu), .q(nu_d));
  g2e_dly #(.W(2 * SC_W), .D(TDLY)) u_latd (
    .clk(clk), .en(en), .d({clat, slat}), .q({clat_d, slat_d})
  );
  g2e_dly #(.W(2 * SC_W), .D(TDLY + SMUL_LAT)) u_lond (
    .clk(clk), .en(en), .d({clon, slon}), .q({clon_d, slon_d})
  );

  g2e_mul u_nz (.clk(clk), .en(en), .a(64'(ONE48 - 49'(ecc_r))), .b(nu), .p(pz));

  always_ff @(posedge clk) begin
    if (en) begin
      nh_r <= signed'(nu_d) + 64'(h_d);
      nz_r <= signed'(pz[111:48]) + 64'(h_d);
    end
  end

  g2e_smul u_pc (.clk(clk), .en(en), .a(nh_r), .b(64'(clat_d)), .p(pc));
  g2e_smul u_zs (.clk(clk), .en(en), .a(nz_r), .b(64'(slat_d)), .p(zs));
  g2e_dly #(.W(64), .D(SMUL_LAT)) u_zd (.clk(clk), .en(en), .d(zs), .q(zs_d));
  g2e_smul u_xs (.clk(clk), .en(en), .a(pc), .b(64'(clon_d)), .p(xs));
  g2e_smul u_ys (.clk(clk), .en(en), .a(pc), .b(64'(slon_d)), .p(ys));

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= (xs > SAT_HI) ? CRD_W'(SAT_HI) : (xs < SAT_LO) ? CRD_W'(SAT_LO) : CRD_W'(xs);
      y_r <= (ys > SAT_HI) ? CRD_W'(SAT_HI) : (ys < SAT_LO) ? CRD_W'(SAT_LO) : CRD_W'(ys);
      z_r <= (zs_d > SAT_HI) ? CRD_W'(SAT_HI) : (zs_d < SAT_LO) ? CRD_W'(SAT_LO) : CRD_W'(zs_d);
    end
  end

  assign out_coord_x = x_r;
  assign out_coord_y = y_r;
  assign out_coord_z = z_r;

`ifndef SYNTHESIS
  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vld_r))
    else $error("pipeline valid bits moved during an output stall");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted beat did not enter the pipeline");

  a_trig: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[TC-1] |-> (64'(clat) <= 64'(ONE40)) && (64'(clat) >= -64'(ONE40)) &&
                    (64'(slat) <= 64'(ONE40)) && (64'(slat) >= -64'(ONE40)))
    else $error("latitude sine or cosine beyond unity");
`endif

endmodule
